/* rtl/core/dpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpg_pkg
// shared constants, types and helper functions for the particle grower
// ----------------------------------------------------------------------------
package dpg_pkg;

  // grid geometry and timing
  localparam int GRID_W      = 64;
  localparam int GRID_H      = 32;
  localparam int FADE_FRAMES = 45;

  localparam int NCELLS   = GRID_W * GRID_H;
  localparam int MIN_WH   = (GRID_W < GRID_H) ? GRID_W : GRID_H;
  localparam int CENTRE_X = GRID_W / 2;
  localparam int CENTRE_Y = GRID_H / 2;

  localparam int X_W    = 6;
  localparam int Y_W    = 5;
  localparam int ADDR_W = $clog2(NCELLS);
  localparam int CELL_W = 7;
  localparam int CRD_W  = 10;
  localparam int BR_W   = 10;
  localparam int CNT_W  = 12;
  localparam int AGE_W  = 6;
  localparam int FADE_W = 6;
  localparam int STEP_W = 10;
  localparam int RAD_W  = 24;
  localparam int ROOT_W = 12;

  localparam int BR_RESET   = 80;
  localparam int BR_CAP     = MIN_WH * 8 - 32;
  localparam int FADE_R     = MIN_WH * 8 - 48;
  localparam int COUNT_LIM  = NCELLS / 6;
  localparam int COUNT_MAX  = 4095;
  localparam int BR_MAX     = 1023;

  // item kinds
  typedef enum logic [1:0] {
    KIND_LAUNCH = 2'd0,
    KIND_STEP   = 2'd1,
    KIND_FRAME  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LAUNCH,
    ST_STEP,
    ST_NBR,
    ST_DECIDE,
    ST_SQRT,
    ST_STICK,
    ST_FRAME,
    ST_READ,
    ST_READ_DATA,
    ST_OUT
  } state_t;

  // cos(2*pi*k/64) in Q1.14
  function automatic logic [14:0] quarter_cos(input logic [4:0] q);
    logic [14:0] v;
    case (q)
      5'd0:    v = 15'd16384;
      5'd1:    v = 15'd16305;
      5'd2:    v = 15'd16069;
      5'd3:    v = 15'd15679;
      5'd4:    v = 15'd15137;
      5'd5:    v = 15'd14449;
      5'd6:    v = 15'd13623;
      5'd7:    v = 15'd12665;
      5'd8:    v = 15'd11585;
      5'd9:    v = 15'd10394;
      5'd10:   v = 15'd9102;
      5'd11:   v = 15'd7723;
      5'd12:   v = 15'd6270;
      5'd13:   v = 15'd4756;
      5'd14:   v = 15'd3196;
      5'd15:   v = 15'd1606;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // magnitude and sign of the circle table entry
  function automatic logic [15:0] cos_q14(input logic [5:0] k);
    logic [4:0] q;
    logic [4:0] qr;
    logic [15:0] r;
    q  = {1'b0, k[3:0]};
    qr = 5'd16 - q;
    case (k[5:4])
      2'd0:    r = {1'b0, quarter_cos(q)};
      2'd1:    r = {1'b1, quarter_cos(qr)};
      2'd2:    r = {1'b1, quarter_cos(q)};
      default: r = {1'b0, quarter_cos(qr)};
    endcase
    return r;
  endfunction

  // step code: 0 none, 1 plus one, anything else minus one
  function automatic logic signed [CRD_W-1:0] decode_step(input logic [1:0] v);
    logic signed [CRD_W-1:0] r;
    case (v)
      2'd0:    r = '0;
      2'd1:    r = CRD_W'(1);
      default: r = -CRD_W'(1);
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                  input logic [Y_W-1:0] y);
    return ADDR_W'(y) * ADDR_W'(GRID_W) + ADDR_W'(x);
  endfunction

endpackage

/* rtl/core/dpg_cell_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpg_cell_mem
// grid cell memory, one write and one registered read port
// ----------------------------------------------------------------------------
module dpg_cell_mem
  import dpg_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [NCELLS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/dpg_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpg_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module dpg_isqrt
  import dpg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0] rem;
  logic [RAD_W-1:0] res;
  logic [RAD_W-1:0] bitv;
  logic             active;
  logic [RAD_W-1:0] trial;

  assign trial = res + bitv;
  assign done  = active && (bitv == '0);
  assign root  = res[ROOT_W-1:0];

  // one bit pair per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      bitv   <= '0;
    end else if (start) begin
      active <= 1'b1;
      rem    <= radicand;
      res    <= '0;
      bitv   <= RAD_W'(1) << (2 * ROOT_W - 2);
    end else if (active && bitv != '0) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

/* rtl/core/dla_particle_grower.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dla_particle_grower
// diffusion-limited aggregation grid with walker launch, walk, fade and read
// ----------------------------------------------------------------------------
// the walk step is paced by four neighbour reads through the single cell memory
// read port, a sticking step by the square root unit. one item at a time; next
// item taken after the output beat. reset and every regrow run a clearing pass
// over the grid (one cell a cycle) during which no input beat is taken.
module dla_particle_grower
  import dpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // angle_index[5:0], step_x[7:6], step_y[9:8], read_x[15:10], read_y[20:16]
  input  logic [23:0] s_tdata,
  // kind[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cell_value[6:0], stuck[7], walker_live[8], fading[9], restarted[10]
  output logic [15:0] m_tdata
);

  state_t state, state_next;

  // latched item
  logic [5:0]  angle_index;
  logic [1:0]  step_x;
  logic [1:0]  step_y;
  logic [5:0]  read_x;
  logic [4:0]  read_y;

  // grower state
  logic [BR_W-1:0]   birth_radius;
  logic [CNT_W-1:0]  particle_count;
  logic [AGE_W-1:0]  age_tag;
  logic [FADE_W-1:0] fade_left;
  logic [X_W-1:0]    walker_x;
  logic [Y_W-1:0]    walker_y;
  logic [STEP_W-1:0] steps_taken;
  logic              walker_active;

  // sequencing and result
  logic [ADDR_W-1:0] clr_cnt;
  logic [2:0]        nbr_cnt;
  logic              nbr_hit;
  logic              clr_pend;
  logic [CELL_W-1:0] cell_value;
  logic              stuck;
  logic              restarted;

  // memory ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // square root
  logic              sq_start;
  logic [RAD_W-1:0]  sq_rad;
  logic              sq_done;
  logic [ROOT_W-1:0] sq_root;

  logic in_beat;
  logic out_beat;
  assign in_beat  = s_tvalid && s_tready;
  assign out_beat = m_tvalid && m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {5'd0, restarted, (fade_left != '0), walker_active, stuck, cell_value};

  dpg_cell_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dpg_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .done     (sq_done),
    .root     (sq_root)
  );

  // launch position from the circle table
  logic [15:0]             cos_x, cos_y;
  logic [24:0]             prod_x, prod_y;
  logic signed [CRD_W-1:0] off_x, off_y, pos_x, pos_y, lx, ly;
  always_comb begin
    cos_x  = cos_q14(angle_index);
    cos_y  = cos_q14(angle_index + 6'd48);
    prod_x = 25'(cos_x[14:0]) * 25'(birth_radius);
    prod_y = 25'(cos_y[14:0]) * 25'(birth_radius);
    off_x  = CRD_W'(prod_x[24:18]);
    off_y  = CRD_W'(prod_y[24:18]);
    pos_x  = cos_x[15] ? CRD_W'(CENTRE_X) - off_x : CRD_W'(CENTRE_X) + off_x;
    pos_y  = cos_y[15] ? CRD_W'(CENTRE_Y) - off_y : CRD_W'(CENTRE_Y) + off_y;
    lx = (pos_x < CRD_W'(1)) ? CRD_W'(1) :
         (pos_x > CRD_W'(GRID_W - 2)) ? CRD_W'(GRID_W - 2) : pos_x;
    ly = (pos_y < CRD_W'(1)) ? CRD_W'(1) :
         (pos_y > CRD_W'(GRID_H - 2)) ? CRD_W'(GRID_H - 2) : pos_y;
  end

  // walk move and interior test
  logic signed [CRD_W-1:0] nx, ny;
  logic                    outside;
  logic [STEP_W-1:0]       steps_inc;
  logic [10:0]             step_limit;
  always_comb begin
    nx = $signed(CRD_W'(walker_x)) + decode_step(step_x);
    ny = $signed(CRD_W'(walker_y)) + decode_step(step_y);
    outside = (nx < CRD_W'(1)) || (nx >= CRD_W'(GRID_W - 1)) ||
              (ny < CRD_W'(1)) || (ny >= CRD_W'(GRID_H - 1));
    steps_inc  = steps_taken + STEP_W'(1);
    step_limit = 11'((14'(birth_radius) * 14'd10) >> 4) + 11'd200;
  end

  // distance from the centre, squared and scaled for the root
  logic signed [CRD_W-1:0] dx, dy;
  logic [2*CRD_W-1:0]      d2;
  always_comb begin
    dx     = $signed(CRD_W'(walker_x)) - CRD_W'(CENTRE_X);
    dy     = $signed(CRD_W'(walker_y)) - CRD_W'(CENTRE_Y);
    d2     = (2*CRD_W)'(dx * dx) + (2*CRD_W)'(dy * dy);
    sq_rad = RAD_W'(d2) << 8;
  end

  // radius growth after sticking
  logic [ROOT_W:0] d_near, d_far;
  logic [ROOT_W:0] new_r;
  always_comb begin
    d_near = (ROOT_W+1)'(sq_root) + (ROOT_W+1)'(48);
    d_far  = (ROOT_W+1)'(sq_root) + (ROOT_W+1)'(96);
    new_r  = (d_far > (ROOT_W+1)'(BR_CAP)) ? (ROOT_W+1)'(BR_CAP) : d_far;
    if (new_r > (ROOT_W+1)'(BR_MAX)) begin
      new_r = (ROOT_W+1)'(BR_MAX);
    end
  end

  // fade countdown on a frame beat
  logic [FADE_W-1:0] fade_start, fade_dec;
  logic              regrow;
  always_comb begin
    fade_start = fade_left;
    if (fade_left == '0 && ((birth_radius >= BR_W'(FADE_R)) ||
                            (particle_count > CNT_W'(COUNT_LIM)))) begin
      fade_start = FADE_W'(FADE_FRAMES);
    end
    fade_dec = (fade_start != '0) ? fade_start - FADE_W'(1) : fade_start;
    regrow   = (fade_start != '0) && (fade_dec == '0);
  end

  // neighbour address for the current read slot
  logic [ADDR_W-1:0] nbr_addr;
  always_comb begin
    case (nbr_cnt[1:0])
      2'd0:    nbr_addr = cell_addr(walker_x - X_W'(1), walker_y);
      2'd1:    nbr_addr = cell_addr(walker_x + X_W'(1), walker_y);
      2'd2:    nbr_addr = cell_addr(walker_x, walker_y - Y_W'(1));
      default: nbr_addr = cell_addr(walker_x, walker_y + Y_W'(1));
    endcase
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = cell_addr(walker_x, walker_y);
    mem_wdata  = CELL_W'(age_tag) + CELL_W'(1);
    mem_re     = 1'b0;
    mem_raddr  = nbr_addr;
    sq_start   = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = (clr_cnt == cell_addr(X_W'(CENTRE_X), Y_W'(CENTRE_Y))) ?
                    CELL_W'(1) : '0;
        if (clr_cnt == ADDR_W'(NCELLS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          case (kind_t'(s_tuser))
            KIND_LAUNCH: state_next = ST_LAUNCH;
            KIND_STEP:   state_next = ST_STEP;
            KIND_FRAME:  state_next = ST_FRAME;
            default:     state_next = ST_READ;
          endcase
        end
      end
      ST_LAUNCH: state_next = ST_OUT;
      ST_STEP: begin
        if (!walker_active || outside) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_NBR;
        end
      end
      ST_NBR: begin
        mem_re = (nbr_cnt < 3'd4);
        if (nbr_cnt == 3'd4) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (nbr_hit) begin
          sq_start   = 1'b1;
          state_next = ST_SQRT;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          state_next = ST_STICK;
        end
      end
      ST_STICK: begin
        mem_we     = 1'b1;
        state_next = ST_OUT;
      end
      ST_FRAME: state_next = ST_OUT;
      ST_READ: begin
        mem_re     = 1'b1;
        mem_raddr  = cell_addr(read_x, read_y);
        state_next = ST_READ_DATA;
      end
      ST_READ_DATA: state_next = ST_OUT;
      ST_OUT: begin
        if (out_beat) begin
          state_next = clr_pend ? ST_CLEAR : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (in_beat) begin
      angle_index <= s_tdata[5:0];
      step_x      <= s_tdata[7:6];
      step_y      <= s_tdata[9:8];
      read_x      <= s_tdata[15:10];
      read_y      <= s_tdata[20:16];
    end
  end

  // grower state and result fields
  always_ff @(posedge clk) begin
    if (rst) begin
      birth_radius   <= BR_W'(BR_RESET);
      particle_count <= '0;
      age_tag        <= '0;
      fade_left      <= '0;
      walker_x       <= '0;
      walker_y       <= '0;
      steps_taken    <= '0;
      walker_active  <= 1'b0;
      clr_cnt        <= '0;
      clr_pend       <= 1'b0;
      nbr_cnt        <= '0;
      nbr_hit        <= 1'b0;
      cell_value     <= '0;
      stuck          <= 1'b0;
      restarted      <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt  <= clr_cnt + ADDR_W'(1);
          clr_pend <= 1'b0;
        end
        ST_IDLE: begin
          if (in_beat) begin
            cell_value <= '0;
            stuck      <= 1'b0;
            restarted  <= 1'b0;
            nbr_cnt    <= '0;
            nbr_hit    <= 1'b0;
          end
        end
        ST_LAUNCH: begin
          walker_x      <= X_W'(lx);
          walker_y      <= Y_W'(ly);
          steps_taken   <= '0;
          walker_active <= 1'b1;
        end
        ST_STEP: begin
          if (walker_active) begin
            steps_taken <= steps_inc;
            if (outside) begin
              walker_active <= 1'b0;
            end else begin
              walker_x <= X_W'(nx);
              walker_y <= Y_W'(ny);
            end
          end
        end
        ST_NBR: begin
          nbr_cnt <= nbr_cnt + 3'd1;
          if (nbr_cnt != 3'd0 && mem_rdata != '0) begin
            nbr_hit <= 1'b1;
          end
        end
        ST_DECIDE: begin
          if (!nbr_hit && (11'(steps_taken) >= step_limit)) begin
            walker_active <= 1'b0;
          end
        end
        ST_STICK: begin
          if (d_near > (ROOT_W+1)'(birth_radius)) begin
            birth_radius <= BR_W'(new_r);
          end
          if (particle_count < CNT_W'(COUNT_MAX)) begin
            particle_count <= particle_count + CNT_W'(1);
          end
          walker_active <= 1'b0;
          stuck         <= 1'b1;
        end
        ST_FRAME: begin
          if (regrow) begin
            birth_radius   <= BR_W'(BR_RESET);
            particle_count <= '0;
            age_tag        <= '0;
            fade_left      <= '0;
            walker_x       <= '0;
            walker_y       <= '0;
            steps_taken    <= '0;
            walker_active  <= 1'b0;
            restarted      <= 1'b1;
            clr_pend       <= 1'b1;
            clr_cnt        <= '0;
          end else begin
            age_tag   <= age_tag + AGE_W'(1);
            fade_left <= fade_dec;
          end
        end
        ST_READ_DATA: begin
          cell_value <= mem_rdata;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
